// File: design/a2k_pkg.sv
package a2k_pkg;

	localparam logic [7:0] KEY_SHIFT = 8'h10;
	localparam logic [7:0] KEY_ALTGR = 8'hA5;
	localparam logic [7:0] CHAR_CR   = 8'h0D;

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		REG_LAYOUT      = 2'd0,
		REG_CHAR_DELAY  = 2'd1,
		REG_ENTER_DELAY = 2'd2,
		REG_RELEASE     = 2'd3
	} reg_index_t;

	localparam logic        LAYOUT_RESET      = 1'b0;
	localparam logic [15:0] CHAR_DELAY_RESET  = 16'd50;
	localparam logic [15:0] ENTER_DELAY_RESET = 16'd50;
	localparam logic        RELEASE_RESET     = 1'b1;

	typedef enum logic [1:0] {
		MOD_NONE  = 2'd0,
		MOD_SHIFT = 2'd1,
		MOD_ALTGR = 2'd2
	} mod_t;

	typedef struct packed {
		logic [7:0] key;
		mod_t       modifier;
	} key_map_t;

	typedef struct packed {
		logic [7:0] key;
		mod_t       modifier;
		logic       is_cr;
	} key_job_t;

	typedef struct packed {
		logic [7:0]  key_code;
		logic        key_up;
		logic [15:0] wait_ms;
		logic        last;
	} key_event_t;

	function automatic key_map_t pick(input logic azerty, input logic [7:0] qkey,
			input mod_t qmod, input logic [7:0] akey, input mod_t amod);
		key_map_t r;
		r.key      = azerty ? akey : qkey;
		r.modifier = azerty ? amod : qmod;
		return r;
	endfunction

	function automatic key_map_t translate(input logic [7:0] c, input logic azerty);
		key_map_t r;
		r.key      = c;
		r.modifier = MOD_NONE;
		if (c inside {[8'h41:8'h5A]}) begin
			r.modifier = MOD_SHIFT;
		end else if (c inside {[8'h30:8'h39]}) begin
			r.key = c + 8'd48;
		end else if (c inside {[8'h61:8'h7A]}) begin
			r.key = c - 8'd32;
		end else begin
			case (c)
				8'h21: r = pick(azerty, 8'h31, MOD_SHIFT, 8'hDF, MOD_NONE);
				8'h22: r = pick(azerty, 8'hDE, MOD_SHIFT, 8'h33, MOD_NONE);
				8'h23: r = pick(azerty, 8'h33, MOD_SHIFT, 8'h33, MOD_ALTGR);
				8'h24: r = pick(azerty, 8'h34, MOD_SHIFT, 8'hBA, MOD_NONE);
				8'h25: r = pick(azerty, 8'h35, MOD_SHIFT, 8'hC0, MOD_SHIFT);
				8'h26: r = pick(azerty, 8'h37, MOD_SHIFT, 8'h31, MOD_NONE);
				8'h27: r = pick(azerty, 8'hDE, MOD_NONE,  8'h34, MOD_NONE);
				8'h28: r = pick(azerty, 8'h39, MOD_SHIFT, 8'h35, MOD_NONE);
				8'h29: r = pick(azerty, 8'h30, MOD_SHIFT, 8'hDB, MOD_NONE);
				8'h2A: r = pick(azerty, 8'h6A, MOD_NONE,  8'h6A, MOD_NONE);
				8'h2B: r = pick(azerty, 8'h6B, MOD_NONE,  8'h6B, MOD_NONE);
				8'h2C: r = pick(azerty, 8'hBC, MOD_NONE,  8'hBC, MOD_NONE);
				8'h2D: r = pick(azerty, 8'h6D, MOD_NONE,  8'h6D, MOD_NONE);
				8'h2E: r = pick(azerty, 8'h6E, MOD_NONE,  8'h6E, MOD_NONE);
				8'h2F: r = pick(azerty, 8'hBF, MOD_SHIFT, 8'hBF, MOD_SHIFT);
				8'h3A: r = pick(azerty, 8'hBA, MOD_SHIFT, 8'hBF, MOD_NONE);
				8'h3B: r = pick(azerty, 8'hBA, MOD_NONE,  8'hBE, MOD_NONE);
				8'h3C: r = pick(azerty, 8'hBC, MOD_SHIFT, 8'hE2, MOD_NONE);
				8'h3D: r = pick(azerty, 8'hBB, MOD_NONE,  8'hBB, MOD_NONE);
				8'h3E: r = pick(azerty, 8'hBE, MOD_SHIFT, 8'hE2, MOD_SHIFT);
				8'h3F: r = pick(azerty, 8'hBF, MOD_SHIFT, 8'hBC, MOD_SHIFT);
				8'h40: r = pick(azerty, 8'h32, MOD_SHIFT, 8'h30, MOD_ALTGR);
				8'h5B: r = pick(azerty, 8'hDB, MOD_NONE,  8'h35, MOD_ALTGR);
				8'h5C: r = pick(azerty, 8'hDC, MOD_NONE,  8'h38, MOD_ALTGR);
				8'h5D: r = pick(azerty, 8'hDD, MOD_NONE,  8'hDB, MOD_ALTGR);
				8'h5E: r = pick(azerty, 8'h36, MOD_SHIFT, 8'h39, MOD_ALTGR);
				8'h5F: r = pick(azerty, 8'hBD, MOD_SHIFT, 8'h38, MOD_NONE);
				8'h7B: r = pick(azerty, 8'hDB, MOD_SHIFT, 8'h34, MOD_ALTGR);
				8'h7C: r = pick(azerty, 8'hDC, MOD_SHIFT, 8'h36, MOD_ALTGR);
				8'h7D: r = pick(azerty, 8'hDD, MOD_SHIFT, 8'hBB, MOD_ALTGR);
				default: r.key = c;
			endcase
		end
		return r;
	endfunction

endpackage

// File: design/a2k_front.sv
module a2k_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	input  logic [7:0]        char_code,
	input  logic              layout,
	output logic              job_valid,
	input  logic              job_ready,
	output a2k_pkg::key_job_t job
);
	import a2k_pkg::*;

	logic     valid_s1;
	key_job_t job_s1;
	key_map_t map;

	assign map       = translate(char_code, layout);
	assign in_ready  = !valid_s1 || job_ready;
	assign job_valid = valid_s1;
	assign job       = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			if (mode) begin
				job_s1.key      <= char_code;
				job_s1.modifier <= MOD_NONE;
				job_s1.is_cr    <= 1'b0;
			end else begin
				job_s1.key      <= map.key;
				job_s1.modifier <= map.modifier;
				job_s1.is_cr    <= (char_code == CHAR_CR);
			end
		end
	end

endmodule

// File: design/a2k_queue.sv
module a2k_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  a2k_pkg::key_job_t push_job,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output a2k_pkg::key_job_t head
);
	import a2k_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	key_job_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// File: design/a2k_back.sv
module a2k_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  a2k_pkg::key_job_t   job,
	output logic                job_done,
	input  logic                release_keys,
	input  logic [15:0]         char_delay_ms,
	input  logic [15:0]         enter_delay_ms,
	output logic                out_valid,
	input  logic                out_ready,
	output a2k_pkg::key_event_t out_event
);
	import a2k_pkg::*;

	logic [1:0]  step_q;
	logic        out_valid_q;
	key_event_t  event_q;
	logic [7:0]  ev_key [4];
	logic        ev_up  [4];
	logic [1:0]  last_step;
	logic        is_last;
	logic        fire;

	always_comb begin
		ev_key[0] = job.key;
		ev_up[0]  = 1'b0;
		ev_key[1] = job.key;
		ev_up[1]  = 1'b1;
		ev_key[2] = job.key;
		ev_up[2]  = 1'b1;
		ev_key[3] = job.key;
		ev_up[3]  = 1'b1;
		last_step = release_keys ? 2'd1 : 2'd0;
		case (job.modifier)
			MOD_SHIFT: begin
				ev_key[0] = KEY_SHIFT;
				ev_up[0]  = 1'b0;
				ev_key[1] = job.key;
				ev_up[1]  = 1'b0;
				ev_key[2] = release_keys ? job.key : KEY_SHIFT;
				ev_up[2]  = 1'b1;
				ev_key[3] = KEY_SHIFT;
				ev_up[3]  = 1'b1;
				last_step = release_keys ? 2'd3 : 2'd2;
			end
			MOD_ALTGR: begin
				ev_key[0] = KEY_ALTGR;
				ev_up[0]  = 1'b0;
				ev_key[1] = job.key;
				ev_up[1]  = 1'b0;
				ev_key[2] = KEY_ALTGR;
				ev_up[2]  = 1'b1;
				ev_key[3] = job.key;
				ev_up[3]  = 1'b1;
				last_step = release_keys ? 2'd3 : 2'd2;
			end
			default: begin
			end
		endcase
	end

	assign is_last   = (step_q == last_step);
	assign fire      = job_valid && (!out_valid_q || out_ready);
	assign job_done  = fire && is_last;
	assign out_valid = out_valid_q;
	assign out_event = event_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				step_q      <= is_last ? 2'd0 : step_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			event_q.key_code <= ev_key[step_q];
			event_q.key_up   <= ev_up[step_q];
			event_q.wait_ms  <= (is_last && job.is_cr) ? enter_delay_ms : char_delay_ms;
			event_q.last     <= is_last;
		end
	end

endmodule

// File: design/ascii_to_key_event_sequencer_unit.sv
// Path: the first key event of a character passes the front job register, the job queue
// and the event output register. Throughput: one key event per cycle while the output
// is not stalled; a character makes one to four key events in the event sequencer, which
// sets the rate; input beats are taken every cycle while the two-entry job queue has room.
// Reset: arst_n clears all control state and loads qwerty, 50 ms delays, key release on.
module ascii_to_key_event_sequencer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
	input  logic        s_axis_tuser,  // [0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] key_code, [23:8] wait_ms
	output logic        m_axis_tuser,  // [0] key_up
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import a2k_pkg::*;

	logic        layout_q;
	logic [15:0] char_delay_q;
	logic [15:0] enter_delay_q;
	logic        release_q;

	logic        front_valid;
	key_job_t    front_job;
	logic        q_full;
	logic        q_not_empty;
	key_job_t    q_head;
	logic        job_done;
	key_event_t  out_event;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q      <= LAYOUT_RESET;
			char_delay_q  <= CHAR_DELAY_RESET;
			enter_delay_q <= ENTER_DELAY_RESET;
			release_q     <= RELEASE_RESET;
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_LAYOUT:      layout_q      <= cfg_data[0];
				REG_CHAR_DELAY:  char_delay_q  <= cfg_data;
				REG_ENTER_DELAY: enter_delay_q <= cfg_data;
				REG_RELEASE:     release_q     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	a2k_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.mode      (s_axis_tuser),
		.char_code (s_axis_tdata),
		.layout    (layout_q),
		.job_valid (front_valid),
		.job_ready (!q_full),
		.job       (front_job)
	);

	a2k_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid && !q_full),
		.push_job  (front_job),
		.full      (q_full),
		.pop       (job_done),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	a2k_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_valid      (q_not_empty),
		.job            (q_head),
		.job_done       (job_done),
		.release_keys   (release_q),
		.char_delay_ms  (char_delay_q),
		.enter_delay_ms (enter_delay_q),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_event      (out_event)
	);

	assign m_axis_tdata = {out_event.wait_ms, out_event.key_code};
	assign m_axis_tuser = out_event.key_up;
	assign m_axis_tlast = out_event.last;

endmodule

// File: tb/key_event_checker.sv
module key_event_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
	input  logic        s_axis_tuser,  // [0] mode
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,  // [7:0] key_code, [23:8] wait_ms
	input  logic        m_axis_tuser,  // [0] key_up
	input  logic        m_axis_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int unsigned mismatch_count,
	output int unsigned events_due,
	output int unsigned events_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import a2k_pkg::*;

	typedef struct packed {
		logic [7:0] qkey;
		mod_t       qmod;
		logic [7:0] akey;
		mod_t       amod;
	} glyph_t;

	logic        azerty     = LAYOUT_RESET;
	logic [15:0] char_wait  = CHAR_DELAY_RESET;
	logic [15:0] enter_wait = ENTER_DELAY_RESET;
	logic        release_on = RELEASE_RESET;

	key_event_t expected_keys [$];
	key_event_t want;
	key_event_t got;
	logic       bad;

	function automatic glyph_t glyph_of(input logic [7:0] c);
		case (c)
			8'h21: return '{8'h31, MOD_SHIFT, 8'hDF, MOD_NONE};
			8'h22: return '{8'hDE, MOD_SHIFT, 8'h33, MOD_NONE};
			8'h23: return '{8'h33, MOD_SHIFT, 8'h33, MOD_ALTGR};
			8'h24: return '{8'h34, MOD_SHIFT, 8'hBA, MOD_NONE};
			8'h25: return '{8'h35, MOD_SHIFT, 8'hC0, MOD_SHIFT};
			8'h26: return '{8'h37, MOD_SHIFT, 8'h31, MOD_NONE};
			8'h27: return '{8'hDE, MOD_NONE,  8'h34, MOD_NONE};
			8'h28: return '{8'h39, MOD_SHIFT, 8'h35, MOD_NONE};
			8'h29: return '{8'h30, MOD_SHIFT, 8'hDB, MOD_NONE};
			8'h2A: return '{8'h6A, MOD_NONE,  8'h6A, MOD_NONE};
			8'h2B: return '{8'h6B, MOD_NONE,  8'h6B, MOD_NONE};
			8'h2C: return '{8'hBC, MOD_NONE,  8'hBC, MOD_NONE};
			8'h2D: return '{8'h6D, MOD_NONE,  8'h6D, MOD_NONE};
			8'h2E: return '{8'h6E, MOD_NONE,  8'h6E, MOD_NONE};
			8'h2F: return '{8'hBF, MOD_SHIFT, 8'hBF, MOD_SHIFT};
			8'h3A: return '{8'hBA, MOD_SHIFT, 8'hBF, MOD_NONE};
			8'h3B: return '{8'hBA, MOD_NONE,  8'hBE, MOD_NONE};
			8'h3C: return '{8'hBC, MOD_SHIFT, 8'hE2, MOD_NONE};
			8'h3D: return '{8'hBB, MOD_NONE,  8'hBB, MOD_NONE};
			8'h3E: return '{8'hBE, MOD_SHIFT, 8'hE2, MOD_SHIFT};
			8'h3F: return '{8'hBF, MOD_SHIFT, 8'hBC, MOD_SHIFT};
			8'h40: return '{8'h32, MOD_SHIFT, 8'h30, MOD_ALTGR};
			8'h5B: return '{8'hDB, MOD_NONE,  8'h35, MOD_ALTGR};
			8'h5C: return '{8'hDC, MOD_NONE,  8'h38, MOD_ALTGR};
			8'h5D: return '{8'hDD, MOD_NONE,  8'hDB, MOD_ALTGR};
			8'h5E: return '{8'h36, MOD_SHIFT, 8'h39, MOD_ALTGR};
			8'h5F: return '{8'hBD, MOD_SHIFT, 8'h38, MOD_NONE};
			8'h7B: return '{8'hDB, MOD_SHIFT, 8'h34, MOD_ALTGR};
			8'h7C: return '{8'hDC, MOD_SHIFT, 8'h36, MOD_ALTGR};
			8'h7D: return '{8'hDD, MOD_SHIFT, 8'hBB, MOD_ALTGR};
			default: return '{c, MOD_NONE, c, MOD_NONE};
		endcase
	endfunction

	task automatic resolve_key(input logic [7:0] c, output logic [7:0] key, output mod_t md);
		glyph_t g;
		g = glyph_of(c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			key = c;
			md = MOD_SHIFT;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			key = c + 8'd48;
			md = MOD_NONE;
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			key = c - 8'd32;
			md = MOD_NONE;
		end else begin
			key = azerty ? g.akey : g.qkey;
			md = azerty ? g.amod : g.qmod;
		end
	endtask

	task automatic expect_keystrokes(input logic raw, input logic [7:0] c);
		logic [7:0] key;
		mod_t       md;
		logic [8:0] strokes [$];
		key_event_t ev;
		if (raw) begin
			key = c;
			md = MOD_NONE;
		end else begin
			resolve_key(c, key, md);
		end
		if (md == MOD_SHIFT) begin
			strokes.push_back({KEY_SHIFT, 1'b0});
			strokes.push_back({key, 1'b0});
			if (release_on)
				strokes.push_back({key, 1'b1});
			strokes.push_back({KEY_SHIFT, 1'b1});
		end else if (md == MOD_ALTGR) begin
			strokes.push_back({KEY_ALTGR, 1'b0});
			strokes.push_back({key, 1'b0});
			strokes.push_back({KEY_ALTGR, 1'b1});
			if (release_on)
				strokes.push_back({key, 1'b1});
		end else begin
			strokes.push_back({key, 1'b0});
			if (release_on)
				strokes.push_back({key, 1'b1});
		end
		foreach (strokes[i]) begin
			ev.key_code = strokes[i][8:1];
			ev.key_up = strokes[i][0];
			ev.last = (i == strokes.size() - 1);
			ev.wait_ms = (ev.last && !raw && c == CHAR_CR) ? enter_wait : char_wait;
			expected_keys.push_back(ev);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			azerty <= LAYOUT_RESET;
			char_wait <= CHAR_DELAY_RESET;
			enter_wait <= ENTER_DELAY_RESET;
			release_on <= RELEASE_RESET;
			expected_keys.delete();
			events_due <= 0;
			events_checked <= 0;
			mismatch_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LAYOUT:      azerty <= cfg_data[0];
					REG_CHAR_DELAY:  char_wait <= cfg_data;
					REG_ENTER_DELAY: enter_wait <= cfg_data;
					REG_RELEASE:     release_on <= cfg_data[0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				expect_keystrokes(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				got.key_code = m_axis_tdata[7:0];
				got.wait_ms = m_axis_tdata[23:8];
				got.key_up = m_axis_tuser;
				got.last = m_axis_tlast;
				events_checked <= events_checked + 1;
				if (expected_keys.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: unexpected event: code %02h up %0b wait %0d last %0b",
							$realtime, got.key_code, got.key_up, got.wait_ms, got.last);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = expected_keys.pop_front();
					bad = got.key_code !== want.key_code || got.key_up !== want.key_up ||
						got.wait_ms !== want.wait_ms || got.last !== want.last;
					if (bad) begin
						if (mismatch_count < 10) begin
							$display("%0t: expected code %02h up %0b wait %0d last %0b",
								$realtime, want.key_code, want.key_up, want.wait_ms,
								want.last);
							$display("    got code %02h up %0b wait %0d last %0b",
								got.key_code, got.key_up, got.wait_ms, got.last);
						end
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			events_due <= expected_keys.size();
		end
	end

endmodule

// File: tb/ascii_to_key_event_sequencer_unit_tb.sv
module ascii_to_key_event_sequencer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import a2k_pkg::*;

	localparam logic        MODE_TEXT   = 1'b0;
	localparam logic        MODE_RAW    = 1'b1;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 240;
	localparam int unsigned PHASES      = 8;
	localparam int unsigned PHASE_CHARS = 64;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;
	logic        s_axis_tuser  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index     = '0;
	logic [15:0] cfg_data      = '0;

	int unsigned mismatch_count;
	int unsigned events_due;
	int unsigned events_checked;

	int unsigned cycle_count   = 0;
	int unsigned ready_pct     = 100;
	int unsigned hold_requests = 0;
	int unsigned holds_granted = 0;
	int unsigned hold_left     = 0;
	int unsigned burst_left    = 0;
	int unsigned chars_sent    = 0;
	int unsigned settings_used = 0;
	bit          gaps_on       = 1'b1;

	ascii_to_key_event_sequencer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	key_event_checker event_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.events_due(events_due),
		.events_checked(events_checked)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d key events outstanding",
				cycle_count, events_due);
			$display("ascii_to_key_event_sequencer_unit_tb failed");
			$finish;
		end
	end

	// hold off for a long stretch on request, else stall at random
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_granted != hold_requests) begin
			m_axis_tready <= 1'b0;
			holds_granted <= holds_granted + 1;
			hold_left <= HOLD_CYCLES;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
		end
	end

	task automatic send_char(input logic mode, input logic [7:0] c);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = gaps_on ? $urandom_range(0, 8) : 0;
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= c;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
		chars_sent++;
	endtask

	task automatic send_random();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15)
			send_char(MODE_RAW, 8'($urandom_range(0, 255)));
		else if (r < 25)
			send_char(MODE_TEXT, CHAR_CR);
		else if (r < 85)
			send_char(MODE_TEXT, 8'($urandom_range(8'h20, 8'h7E)));
		else
			send_char(MODE_TEXT, 8'($urandom_range(0, 255)));
	endtask

	// drop valid and wait until every expected key event has come back
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (events_due != 0) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic apply_settings(input logic az, input logic [15:0] char_ms,
			input logic [15:0] enter_ms, input logic rel);
		write_reg(REG_LAYOUT, {15'd0, az});
		write_reg(REG_CHAR_DELAY, char_ms);
		write_reg(REG_ENTER_DELAY, enter_ms);
		write_reg(REG_RELEASE, {15'd0, rel});
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [15:0] pick_delay();
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom());
		endcase
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		ready_pct <= 60;

		send_char(MODE_TEXT, 8'h41);
		send_char(MODE_TEXT, 8'h5A);
		send_char(MODE_TEXT, 8'h61);
		send_char(MODE_TEXT, 8'h7A);
		send_char(MODE_TEXT, 8'h30);
		send_char(MODE_TEXT, 8'h39);
		send_char(MODE_TEXT, 8'h21);
		send_char(MODE_TEXT, 8'h40);
		send_char(MODE_TEXT, 8'h5B);
		send_char(MODE_TEXT, CHAR_CR);
		send_char(MODE_TEXT, 8'h00);
		send_char(MODE_TEXT, 8'hFF);
		send_char(MODE_RAW, CHAR_CR);
		send_char(MODE_RAW, 8'h00);
		send_char(MODE_RAW, 8'hFF);

		settle();
		apply_settings(1'b1, 16'hFFFF, 16'h0000, 1'b0);
		send_char(MODE_TEXT, 8'h23);
		send_char(MODE_TEXT, 8'h25);
		send_char(MODE_TEXT, 8'h21);
		send_char(MODE_TEXT, CHAR_CR);
		send_char(MODE_RAW, KEY_ALTGR);

		settle();
		apply_settings(1'b1, 16'h0000, 16'hFFFF, 1'b1);
		send_char(MODE_TEXT, 8'h7B);
		send_char(MODE_TEXT, CHAR_CR);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: apply_settings(1'b0, 16'h0000, 16'h0000, 1'b1);
				1: apply_settings(1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
				default: apply_settings(1'($urandom()), pick_delay(), pick_delay(),
					1'($urandom()));
			endcase
			gaps_on = (ph != 2);
			case (ph)
				2: ready_pct <= 100;
				4: ready_pct <= 25;
				default: ready_pct <= $urandom_range(40, 95);
			endcase
			if (ph == 3)
				hold_requests <= hold_requests + 1;
			repeat (PHASE_CHARS) send_random();
		end

		settle();
		repeat (10) @(posedge clk);
		$display("%0d characters sent over %0d register settings, %0d key events checked",
			chars_sent, settings_used, events_checked);
		if (mismatch_count == 0 && events_due == 0)
			$display("ascii_to_key_event_sequencer_unit_tb passed");
		else
			$display("ascii_to_key_event_sequencer_unit_tb failed");
		$finish;
	end

endmodule

// File: files.f
design/a2k_pkg.sv
design/a2k_front.sv
design/a2k_queue.sv
design/a2k_back.sv
design/ascii_to_key_event_sequencer_unit.sv
tb/key_event_checker.sv
tb/ascii_to_key_event_sequencer_unit_tb.sv
